// ===== src/cfb_pkg.sv =====
// Shared types and constants of the checksummed frame builder.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package cfb_pkg;

  localparam logic [7:0]  SOF_BYTE        = 8'h5A;
  localparam logic [7:0]  EOF_BYTE        = 8'hAA;
  localparam logic [7:0]  PAY_OFFSET      = 8'h33;
  localparam logic [15:0] FRAME_OVERHEAD  = 16'd12;
  localparam logic [15:0] MAX_FRAME_PAY   = 16'd65523;
  localparam logic [12:0] BLOCK_LEN_RESET = 13'd256;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_STATION_ADDR = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAGMENT_CMD = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_BLOCK_LEN    = 2'd2;

  typedef struct packed {
    logic [15:0] station_addr;
    logic [7:0]  fragment_cmd;
    logic [12:0] block_len;
  } cfg_t;

  // One classified transaction: optional header, optional payload byte, optional trailer
  typedef struct packed {
    logic        open;
    logic [15:0] total_len;
    logic [7:0]  seq;
    logic [7:0]  sub;
    logic [7:0]  cmd;
    logic        more;
    logic        has_pay;
    logic [7:0]  pay;
    logic        close;
    logic        last;
    logic        too_long;
  } frame_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== src/checksummed_frame_builder_unit.sv =====
// Checksummed frame builder: payload bytes in, framed and summed bytes out.
// Instantiates cfb_front, cfb_queue and cfb_back; depends on cfb_pkg.
//
// Usage:
//   s_axis carries one payload byte per transaction; tuser marks the first
//   byte of a message, whose length, command, sequence and first-frame length
//   ride in tdata. m_axis carries one frame byte per transaction; tlast marks
//   each 0xAA tail, tuser flags the message's last tail and too-long messages.
// The cfg channel writes station address, fragmenting command and block length
//   and is always ready; the user must write it only while the block is idle (not enforced).
// Path: the first byte caused by an input transaction passes through the
//   command queue and then the registered output stage to m_axis.
// Throughput: one output byte per cycle from the back end's byte sequencer,
//   while m_axis_tready is high and a command is queued. A plain payload byte is
//   one output byte; opening a frame adds nine bytes, closing one three, up to 13.
//   The two-entry command queue lets input run ahead by two transactions.
// Reset: clears message state, queue and output stage; config registers
//   return to address 0, command 0, block length 256.
// Stall: when m_axis_tready is low the output holds, the queue fills and
//   s_axis_tready drops.
`timescale 1ns / 1ps

module checksummed_frame_builder_unit #(
  parameter int unsigned MSG_LEN_BITS = 22,
  localparam int unsigned InBits = 8 + MSG_LEN_BITS + 32,
  localparam int unsigned InW    = ((InBits + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // data_byte, msg_len, cmd_code, msg_seq, first_len, zero fill
  input  logic [InW-1:0]                 s_axis_tdata,
  // msg_start
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // out_byte
  output logic [7:0]                     m_axis_tdata,
  output logic                           m_axis_tlast,
  // msg_end, too_long
  output logic [1:0]                     m_axis_tuser,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cfb_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [cfb_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned LenLo = 8;
  localparam int unsigned CmdLo = LenLo + MSG_LEN_BITS;
  localparam int unsigned SeqLo = CmdLo + 8;
  localparam int unsigned FlLo  = SeqLo + 8;

  cfb_pkg::cfg_t       cfg_q, cfg_d;
  cfb_pkg::frame_cmd_t entry, head;
  cfb_pkg::q_status_t  q_status;
  logic                push, pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_addr_i)
        cfb_pkg::CFG_STATION_ADDR: cfg_d.station_addr = cfg_data_i;
        cfb_pkg::CFG_FRAGMENT_CMD: cfg_d.fragment_cmd = cfg_data_i[7:0];
        cfb_pkg::CFG_BLOCK_LEN:    cfg_d.block_len    = cfg_data_i[12:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.station_addr <= '0;
      cfg_q.fragment_cmd <= '0;
      cfg_q.block_len    <= cfb_pkg::BLOCK_LEN_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  cfb_front #(
    .MSG_LEN_BITS(MSG_LEN_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .data_byte_i (s_axis_tdata[7:0]),
    .msg_start_i (s_axis_tuser),
    .msg_len_i   (s_axis_tdata[LenLo +: MSG_LEN_BITS]),
    .cmd_code_i  (s_axis_tdata[CmdLo +: 8]),
    .msg_seq_i   (s_axis_tdata[SeqLo +: 8]),
    .first_len_i (s_axis_tdata[FlLo +: 16]),
    .q_status_i  (q_status),
    .push_o      (push),
    .entry_o     (entry)
  );

  cfb_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  cfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .frame_end_o (m_axis_tlast),
    .msg_end_o   (m_axis_tuser[0]),
    .too_long_o  (m_axis_tuser[1])
  );

endmodule

// ===== src/cfb_front.sv =====
// Front end: accepts input transactions, tracks message and frame position,
// and classifies each byte into a frame command. Depends on cfb_pkg.
`timescale 1ns / 1ps

module cfb_front #(
  parameter int unsigned MSG_LEN_BITS = 22
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfb_pkg::cfg_t           cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              data_byte_i,
  input  logic                    msg_start_i,
  input  logic [MSG_LEN_BITS-1:0] msg_len_i,
  input  logic [7:0]              cmd_code_i,
  input  logic [7:0]              msg_seq_i,
  input  logic [15:0]             first_len_i,
  input  cfb_pkg::q_status_t      q_status_i,
  output logic                    push_o,
  output cfb_pkg::frame_cmd_t     entry_o
);

  logic [MSG_LEN_BITS-1:0] rem_q, rem_d;
  logic [15:0] frame_left_q, frame_left_d;
  logic [7:0]  sub_q, sub_d, seq_q, seq_d, cmd_q, cmd_d;
  logic        more_q, more_d, split_q, split_d, too_long_q, too_long_d;

  logic        accept;
  logic [31:0] len_x, rem_x;
  logic        split_new, st_more, st_empty, st_close, st_tl;
  logic [15:0] fl0, fl1, st_plen;
  logic [12:0] bl, ct_plen;
  logic        ct_open, ct_more_new, ct_more, ct_close, ct_last;
  logic [7:0]  pay;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;
  assign push_o     = accept && (msg_start_i || (rem_q != '0));

  assign len_x = 32'(msg_len_i);
  assign rem_x = 32'(rem_q);
  assign pay   = data_byte_i + cfb_pkg::PAY_OFFSET;

  assign split_new = (cmd_code_i == cfg_i.fragment_cmd);
  assign fl0       = (first_len_i == 16'd0) ? 16'd1 : first_len_i;
  assign fl1       = (fl0 > cfb_pkg::MAX_FRAME_PAY) ? cfb_pkg::MAX_FRAME_PAY : fl0;
  assign st_more   = split_new && (len_x > 32'(fl1));
  assign st_plen   = st_more ? fl1 : len_x[15:0];
  assign st_empty  = (msg_len_i == '0);
  assign st_close  = st_empty || (split_new ? (st_plen == 16'd1) : (len_x == 32'd1));
  assign st_tl     = !split_new && (len_x > 32'(cfb_pkg::MAX_FRAME_PAY));

  assign bl          = (cfg_i.block_len == 13'd0) ? 13'd1 : cfg_i.block_len;
  assign ct_open     = split_q && (frame_left_q == 16'd0);
  assign ct_more_new = rem_x > 32'(bl);
  assign ct_plen     = ct_more_new ? bl : rem_x[12:0];
  assign ct_more     = ct_open ? ct_more_new : more_q;
  assign ct_close    = split_q ? (ct_open ? (ct_plen == 13'd1) : (frame_left_q == 16'd1))
                               : (rem_x == 32'd1);
  assign ct_last     = split_q ? !ct_more : 1'b1;

  always_comb begin
    entry_o.pay     = pay;
    if (msg_start_i) begin
      entry_o.open      = 1'b1;
      entry_o.total_len = st_plen + cfb_pkg::FRAME_OVERHEAD;
      entry_o.seq       = msg_seq_i;
      entry_o.sub       = 8'd0;
      entry_o.cmd       = cmd_code_i;
      entry_o.more      = st_more;
      entry_o.has_pay   = !st_empty;
      entry_o.close     = st_close;
      entry_o.last      = !st_more;
      entry_o.too_long  = st_tl;
    end else begin
      entry_o.open      = ct_open;
      entry_o.total_len = 16'(ct_plen) + cfb_pkg::FRAME_OVERHEAD;
      entry_o.seq       = seq_q;
      entry_o.sub       = sub_q;
      entry_o.cmd       = cmd_q;
      entry_o.more      = ct_more;
      entry_o.has_pay   = 1'b1;
      entry_o.close     = ct_close;
      entry_o.last      = ct_last;
      entry_o.too_long  = too_long_q;
    end
  end

  always_comb begin
    rem_d        = rem_q;
    frame_left_d = frame_left_q;
    sub_d        = sub_q;
    seq_d        = seq_q;
    cmd_d        = cmd_q;
    more_d       = more_q;
    split_d      = split_q;
    too_long_d   = too_long_q;
    if (push_o) begin
      if (msg_start_i) begin
        rem_d        = st_empty ? '0 : msg_len_i - 1'b1;
        frame_left_d = st_empty ? 16'd0 : st_plen - 16'd1;
        sub_d        = (st_close && st_more) ? 8'd1 : 8'd0;
        seq_d        = msg_seq_i;
        cmd_d        = cmd_code_i;
        more_d       = st_more;
        split_d      = split_new;
        too_long_d   = st_tl;
      end else begin
        rem_d        = rem_q - 1'b1;
        frame_left_d = (ct_open ? 16'(ct_plen) : frame_left_q) - 16'd1;
        more_d       = ct_more;
        sub_d        = sub_q + 8'(ct_close && ct_more);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q        <= '0;
      frame_left_q <= '0;
      sub_q        <= '0;
      seq_q        <= '0;
      cmd_q        <= '0;
      more_q       <= 1'b0;
      split_q      <= 1'b0;
      too_long_q   <= 1'b0;
    end else begin
      rem_q        <= rem_d;
      frame_left_q <= frame_left_d;
      sub_q        <= sub_d;
      seq_q        <= seq_d;
      cmd_q        <= cmd_d;
      more_q       <= more_d;
      split_q      <= split_d;
      too_long_q   <= too_long_d;
    end
  end

endmodule

// ===== src/cfb_queue.sv =====
// Two-entry queue of frame commands between front and back end.
// Depends on cfb_pkg.
`timescale 1ns / 1ps

module cfb_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  cfb_pkg::frame_cmd_t entry_i,
  input  logic                pop_i,
  output cfb_pkg::frame_cmd_t head_o,
  output cfb_pkg::q_status_t  status_o
);

  cfb_pkg::frame_cmd_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == 2'd2);
  assign status_o.empty = (count_q == 2'd0);

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== src/cfb_back.sv =====
// Back end: expands frame commands into bytes, keeps the running sum,
// and drives the registered output stage. Depends on cfb_pkg.
`timescale 1ns / 1ps

module cfb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfb_pkg::cfg_t       cfg_i,
  input  cfb_pkg::frame_cmd_t head_i,
  input  cfb_pkg::q_status_t  q_status_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                frame_end_o,
  output logic                msg_end_o,
  output logic                too_long_o
);

  typedef enum logic [3:0] {
    ST_FIRST, ST_SOF, ST_LEN_LO, ST_LEN_HI, ST_ADR_LO, ST_ADR_HI, ST_SEQ, ST_SUB,
    ST_CMD, ST_FLAGS, ST_PAY, ST_SUM_LO, ST_SUM_HI, ST_TAIL
  } step_e;

  step_e       step_q, step_d, cur, nxt;
  logic [15:0] sum_q, sum_d;
  logic        valid_q, valid_d;
  logic [7:0]  byte_q, byte_d, b;
  logic        fe_q, fe_d, me_q, me_d, tl_q, tl_d;
  logic        adv, emit;

  assign adv   = !valid_q || out_ready_i;
  assign emit  = adv && !q_status_i.empty;
  assign cur   = (step_q == ST_FIRST) ? (head_i.open ? ST_SOF : ST_PAY) : step_q;
  assign pop_o = emit && (nxt == ST_FIRST);

  always_comb begin
    case (cur)
      ST_SOF:    b = cfb_pkg::SOF_BYTE;
      ST_LEN_LO: b = head_i.total_len[7:0];
      ST_LEN_HI: b = head_i.total_len[15:8];
      ST_ADR_LO: b = cfg_i.station_addr[7:0];
      ST_ADR_HI: b = cfg_i.station_addr[15:8];
      ST_SEQ:    b = head_i.seq;
      ST_SUB:    b = head_i.sub;
      ST_CMD:    b = head_i.cmd;
      ST_FLAGS:  b = {7'd0, head_i.more};
      ST_PAY:    b = head_i.pay;
      ST_SUM_LO: b = sum_q[7:0];
      ST_SUM_HI: b = sum_q[15:8];
      ST_TAIL:   b = cfb_pkg::EOF_BYTE;
      default:   b = 8'd0;
    endcase
  end

  always_comb begin
    case (cur)
      ST_SOF:    nxt = ST_LEN_LO;
      ST_LEN_LO: nxt = ST_LEN_HI;
      ST_LEN_HI: nxt = ST_ADR_LO;
      ST_ADR_LO: nxt = ST_ADR_HI;
      ST_ADR_HI: nxt = ST_SEQ;
      ST_SEQ:    nxt = ST_SUB;
      ST_SUB:    nxt = ST_CMD;
      ST_CMD:    nxt = ST_FLAGS;
      ST_FLAGS:  nxt = head_i.has_pay ? ST_PAY : ST_SUM_LO;
      ST_PAY:    nxt = head_i.close ? ST_SUM_LO : ST_FIRST;
      ST_SUM_LO: nxt = ST_SUM_HI;
      ST_SUM_HI: nxt = ST_TAIL;
      default:   nxt = ST_FIRST;
    endcase
  end

  always_comb begin
    step_d  = step_q;
    sum_d   = sum_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    fe_d    = fe_q;
    me_d    = me_q;
    tl_d    = tl_q;
    if (adv) begin
      valid_d = !q_status_i.empty;
    end
    if (emit) begin
      step_d = nxt;
      byte_d = b;
      fe_d   = (cur == ST_TAIL);
      me_d   = (cur == ST_TAIL) && head_i.last;
      tl_d   = head_i.too_long;
      if (cur == ST_SOF) begin
        sum_d = 16'(cfb_pkg::SOF_BYTE);
      end else if (cur != ST_SUM_LO && cur != ST_SUM_HI && cur != ST_TAIL) begin
        sum_d = sum_q + 16'(b);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= ST_FIRST;
      sum_q   <= '0;
      valid_q <= 1'b0;
      byte_q  <= '0;
      fe_q    <= 1'b0;
      me_q    <= 1'b0;
      tl_q    <= 1'b0;
    end else begin
      step_q  <= step_d;
      sum_q   <= sum_d;
      valid_q <= valid_d;
      byte_q  <= byte_d;
      fe_q    <= fe_d;
      me_q    <= me_d;
      tl_q    <= tl_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign frame_end_o = fe_q;
  assign msg_end_o   = me_q;
  assign too_long_o  = tl_q;

endmodule
